// ===== rtl/pbou_pkg.sv =====
// shared constants, operation codes and pipeline control type for the pixel operation unit
package pbou_pkg;

	localparam int PIXEL_WIDTH_DEF = 8;
	localparam int OP_W = 4;

	localparam logic [OP_W-1:0] OP_COPY   = 4'd0;
	localparam logic [OP_W-1:0] OP_ZCOPY  = 4'd1;
	localparam logic [OP_W-1:0] OP_ADD    = 4'd2;
	localparam logic [OP_W-1:0] OP_AVG    = 4'd3;
	localparam logic [OP_W-1:0] OP_ABSDIF = 4'd4;
	localparam logic [OP_W-1:0] OP_SUB    = 4'd5;
	localparam logic [OP_W-1:0] OP_MUL    = 4'd6;
	localparam logic [OP_W-1:0] OP_DIV    = 4'd7;
	localparam logic [OP_W-1:0] OP_AND    = 4'd8;
	localparam logic [OP_W-1:0] OP_OR     = 4'd9;
	localparam logic [OP_W-1:0] OP_XOR    = 4'd10;
	localparam logic [OP_W-1:0] OP_MIN    = 4'd11;
	localparam logic [OP_W-1:0] OP_MAX    = 4'd12;

	typedef struct packed {
		logic valid;
		logic is_div;
		logic div_zero;
	} ctrl_t;

endpackage

// ===== rtl/pixel_binary_op_unit.sv =====
// top level: pixel operation unit with a chain of division cells
// one transaction accepted every cycle, busy never rises and results cannot be stalled
// each result passes the input stage, then the division chain, one cell per numerator
// bit (PIXEL_WIDTH+2), then the output register; every operation takes the same path.
// reset clears op_select to copy and empties the pipeline
module pixel_binary_op_unit #(
	parameter int PIXEL_WIDTH = pbou_pkg::PIXEL_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      op_select_we,
	input  logic [pbou_pkg::OP_W-1:0] op_select_wdata,
	input  logic                      start,
	output logic                      busy,
	input  logic [PIXEL_WIDTH-1:0]    src_pixel,
	input  logic [PIXEL_WIDTH-1:0]    dst_pixel,
	output logic                      result_valid,
	output logic [PIXEL_WIDTH-1:0]    result_pixel
);

	localparam int RW    = PIXEL_WIDTH + 1;
	localparam int NW    = PIXEL_WIDTH + 2;
	localparam int NCELL = NW;
	localparam int LAT   = PIXEL_WIDTH + 4;

	logic [pbou_pkg::OP_W-1:0] op_select_q;
	logic                      accept;

	logic [PIXEL_WIDTH-1:0]   side_c;
	logic [2*PIXEL_WIDTH-1:0] prod_c;

	logic                     valid_s1;
	logic                     is_div_s1;
	logic                     div_zero_s1;
	logic                     is_mul_s1;
	logic [PIXEL_WIDTH-1:0]   side_s1;
	logic [2*PIXEL_WIDTH-1:0] prod_s1;
	logic [NW-1:0]            num_s1;
	logic [RW-1:0]            den_s1;

	pbou_pkg::ctrl_t        chain_ctrl [0:NCELL];
	logic [RW-1:0]          chain_rem  [0:NCELL];
	logic [NW-1:0]          chain_num  [0:NCELL];
	logic [RW-1:0]          chain_den  [0:NCELL];
	logic [NW-1:0]          chain_quo  [0:NCELL];
	logic [PIXEL_WIDTH-1:0] chain_side [0:NCELL];

	logic [PIXEL_WIDTH-1:0] prod_sat;
	logic [PIXEL_WIDTH-1:0] quo_clamped;
	logic [PIXEL_WIDTH-1:0] result_next;

	logic                   result_valid_q;
	logic [PIXEL_WIDTH-1:0] result_pixel_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_select_q <= pbou_pkg::OP_COPY;
		end else if (op_select_we) begin
			op_select_q <= op_select_wdata;
		end
	end

	pbou_op_mux #(.PIXEL_WIDTH(PIXEL_WIDTH)) u_op_mux (
		.op   (op_select_q),
		.s    (src_pixel),
		.d    (dst_pixel),
		.side (side_c),
		.prod (prod_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// quotient is floor((2d + s) / 2s), rounding half up
	always_ff @(posedge clk) begin
		is_div_s1   <= op_select_q == pbou_pkg::OP_DIV;
		is_mul_s1   <= op_select_q == pbou_pkg::OP_MUL;
		div_zero_s1 <= src_pixel == '0;
		side_s1     <= side_c;
		prod_s1     <= prod_c;
		num_s1      <= {1'b0, dst_pixel, 1'b0} + {2'b00, src_pixel};
		den_s1      <= {src_pixel, 1'b0};
	end

	assign prod_sat = (|prod_s1[2*PIXEL_WIDTH-1:PIXEL_WIDTH]) ? '1 : prod_s1[PIXEL_WIDTH-1:0];

	assign chain_ctrl[0] = '{valid: valid_s1, is_div: is_div_s1, div_zero: div_zero_s1};
	assign chain_rem[0]  = '0;
	assign chain_num[0]  = num_s1;
	assign chain_den[0]  = den_s1;
	assign chain_quo[0]  = '0;
	assign chain_side[0] = is_mul_s1 ? prod_sat : side_s1;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		pbou_div_cell #(.PIXEL_WIDTH(PIXEL_WIDTH)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl_in  (chain_ctrl[i]),
			.rem_in   (chain_rem[i]),
			.num_in   (chain_num[i]),
			.den_in   (chain_den[i]),
			.quo_in   (chain_quo[i]),
			.side_in  (chain_side[i]),
			.ctrl_out (chain_ctrl[i+1]),
			.rem_out  (chain_rem[i+1]),
			.num_out  (chain_num[i+1]),
			.den_out  (chain_den[i+1]),
			.quo_out  (chain_quo[i+1]),
			.side_out (chain_side[i+1])
		);
	end

	assign quo_clamped = (|chain_quo[NCELL][NW-1:PIXEL_WIDTH]) ? '1
		: chain_quo[NCELL][PIXEL_WIDTH-1:0];

	always_comb begin
		if (!chain_ctrl[NCELL].is_div) begin
			result_next = chain_side[NCELL];
		end else if (chain_ctrl[NCELL].div_zero) begin
			result_next = '0;
		end else begin
			result_next = quo_clamped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= chain_ctrl[NCELL].valid;
		end
	end

	always_ff @(posedge clk) begin
		result_pixel_q <= result_next;
	end

	assign result_valid = result_valid_q;
	assign result_pixel = result_pixel_q;

	// every accepted transaction gives its strobe after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT result_valid)
		else $error("result strobe missing after accepted transaction");

	// no strobe without a matching accepted transaction
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(accept, LAT))
		else $error("result strobe without a matching transaction");

	// division by zero gives zero
	a_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && $past(accept && op_select_q == pbou_pkg::OP_DIV
			&& src_pixel == '0, LAT) |-> result_pixel == '0)
		else $error("division by zero did not give zero");

	// copy passes the source pixel through the whole chain
	a_copy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && $past(accept && op_select_q == pbou_pkg::OP_COPY, LAT)
			|-> result_pixel == $past(src_pixel, LAT))
		else $error("copy result differs from source pixel");

endmodule

// ===== rtl/pbou_op_mux.sv =====
// operation decoder for the combinational pixel operations and the raw product
module pbou_op_mux #(
	parameter int PIXEL_WIDTH = pbou_pkg::PIXEL_WIDTH_DEF
) (
	input  logic [pbou_pkg::OP_W-1:0] op,
	input  logic [PIXEL_WIDTH-1:0]    s,
	input  logic [PIXEL_WIDTH-1:0]    d,
	output logic [PIXEL_WIDTH-1:0]    side,
	output logic [2*PIXEL_WIDTH-1:0]  prod
);

	logic [PIXEL_WIDTH:0] sum;

	assign sum  = {1'b0, s} + {1'b0, d};
	assign prod = {{PIXEL_WIDTH{1'b0}}, s} * {{PIXEL_WIDTH{1'b0}}, d};

	always_comb begin
		unique case (op)
			pbou_pkg::OP_COPY:   side = s;
			pbou_pkg::OP_ZCOPY:  side = (s != '0) ? s : d;
			pbou_pkg::OP_ADD:    side = sum[PIXEL_WIDTH-1:0];
			pbou_pkg::OP_AVG:    side = sum[PIXEL_WIDTH:1];
			pbou_pkg::OP_ABSDIF: side = (d > s) ? (d - s) : (s - d);
			pbou_pkg::OP_SUB:    side = d - s;
			// product and quotient are resolved further down the pipe
			pbou_pkg::OP_MUL:    side = '0;
			pbou_pkg::OP_DIV:    side = '0;
			pbou_pkg::OP_AND:    side = s & d;
			pbou_pkg::OP_OR:     side = s | d;
			pbou_pkg::OP_XOR:    side = s ^ d;
			pbou_pkg::OP_MIN:    side = (s < d) ? s : d;
			pbou_pkg::OP_MAX:    side = (s > d) ? s : d;
			default:             side = d;
		endcase
	end

endmodule

// ===== rtl/pbou_div_cell.sv =====
// one restoring division step, registered, with the bypass result carried alongside
module pbou_div_cell #(
	parameter int PIXEL_WIDTH = pbou_pkg::PIXEL_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pbou_pkg::ctrl_t             ctrl_in,
	input  logic [PIXEL_WIDTH:0]        rem_in,
	input  logic [PIXEL_WIDTH+1:0]      num_in,
	input  logic [PIXEL_WIDTH:0]        den_in,
	input  logic [PIXEL_WIDTH+1:0]      quo_in,
	input  logic [PIXEL_WIDTH-1:0]      side_in,
	output pbou_pkg::ctrl_t             ctrl_out,
	output logic [PIXEL_WIDTH:0]        rem_out,
	output logic [PIXEL_WIDTH+1:0]      num_out,
	output logic [PIXEL_WIDTH:0]        den_out,
	output logic [PIXEL_WIDTH+1:0]      quo_out,
	output logic [PIXEL_WIDTH-1:0]      side_out
);

	localparam int RW = PIXEL_WIDTH + 1;
	localparam int NW = PIXEL_WIDTH + 2;

	pbou_pkg::ctrl_t ctrl_q;
	logic [RW-1:0]   rem_q;
	logic [NW-1:0]   num_q;
	logic [RW-1:0]   den_q;
	logic [NW-1:0]   quo_q;
	logic [PIXEL_WIDTH-1:0] side_q;

	logic [NW-1:0] trial;
	logic [NW-1:0] diff;
	logic          ge;
	logic [RW-1:0] rem_next;

	// bring down the next numerator bit and try the subtraction
	assign trial    = {rem_in, num_in[NW-1]};
	assign ge       = trial >= {1'b0, den_in};
	assign diff     = trial - {1'b0, den_in};
	assign rem_next = ge ? diff[RW-1:0] : trial[RW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else begin
			ctrl_q <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		rem_q  <= rem_next;
		num_q  <= {num_in[NW-2:0], 1'b0};
		den_q  <= den_in;
		quo_q  <= {quo_in[NW-2:0], ge};
		side_q <= side_in;
	end

	assign ctrl_out = ctrl_q;
	assign rem_out  = rem_q;
	assign num_out  = num_q;
	assign den_out  = den_q;
	assign quo_out  = quo_q;
	assign side_out = side_q;

endmodule

// ===== tb/pixel_binary_op_unit_tb.sv =====
// testbench for the pixel operation unit: directed table, then random phases per operation
module pixel_binary_op_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PW = pbou_pkg::PIXEL_WIDTH_DEF;
	localparam int LATENCY = PW + 4;
	localparam int RANDOM_ITEMS = 525;
	localparam int CYCLE_LIMIT = 100000;
	localparam int N_DIRECTED = 25;

	typedef logic [pbou_pkg::OP_W-1:0] op_code_t;

	// codes that select no operation: the destination passes through
	localparam op_code_t OP_RSVD_LO  = 4'd13;
	localparam op_code_t OP_RSVD_MID = 4'd14;
	localparam op_code_t OP_RSVD_HI  = 4'd15;

	localparam logic [PW-1:0] PIX_MAX = {PW{1'b1}};

	typedef logic [PW-1:0] pixel_t;

	typedef struct packed {
		op_code_t op;
		pixel_t   src;
		pixel_t   dst;
		logic     known;
		pixel_t   pix;
	} vector_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        op_select_we = 1'b0;
	op_code_t    op_select_wdata = '0;
	logic        start = 1'b0;
	logic        busy;
	pixel_t      src_pixel = '0;
	pixel_t      dst_pixel = '0;
	logic        result_valid;
	pixel_t      result_pixel;

	pixel_t      pending_pixels[$];
	op_code_t    active_op = pbou_pkg::OP_COPY;
	int          mismatches = 0;
	int          cycle_count = 0;
	vector_row_t directed_rows [N_DIRECTED];

	pixel_binary_op_unit #(.PIXEL_WIDTH(PW)) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.op_select_we    (op_select_we),
		.op_select_wdata (op_select_wdata),
		.start           (start),
		.busy            (busy),
		.src_pixel       (src_pixel),
		.dst_pixel       (dst_pixel),
		.result_valid    (result_valid),
		.result_pixel    (result_pixel)
	);

	always #6 clk = ~clk;

	function automatic pixel_t new_dst_pixel(input op_code_t op, input pixel_t s,
			input pixel_t d);
		logic [PW:0]     sum;
		logic [2*PW-1:0] prod;
		logic [PW+1:0]   quot;
		pixel_t          r;
		sum = {1'b0, s} + {1'b0, d};
		case (op)
			pbou_pkg::OP_COPY:   r = s;
			pbou_pkg::OP_ZCOPY:  r = (s != '0) ? s : d;
			pbou_pkg::OP_ADD:    r = sum[PW-1:0];
			pbou_pkg::OP_AVG:    r = sum[PW:1];
			pbou_pkg::OP_ABSDIF: r = (d > s) ? d - s : s - d;
			pbou_pkg::OP_SUB:    r = d - s;
			pbou_pkg::OP_MUL: begin
				prod = s * d;
				r = (prod > PIX_MAX) ? PIX_MAX : prod[PW-1:0];
			end
			pbou_pkg::OP_DIV: begin
				if (s == '0) begin
					r = '0;
				end else begin
					// round to nearest, ties up: (2d + s) / 2s
					quot = ({2'b0, d} << 1) + {2'b0, s};
					quot = quot / ({2'b0, s} << 1);
					r = (quot > PIX_MAX) ? PIX_MAX : quot[PW-1:0];
				end
			end
			pbou_pkg::OP_AND: r = s & d;
			pbou_pkg::OP_OR:  r = s | d;
			pbou_pkg::OP_XOR: r = s ^ d;
			pbou_pkg::OP_MIN: r = (s < d) ? s : d;
			pbou_pkg::OP_MAX: r = (s > d) ? s : d;
			default: r = d;
		endcase
		return r;
	endfunction

	function automatic pixel_t rand_pixel();
		pixel_t p;
		case ($urandom_range(0, 9))
			0: p = '0;
			1: p = PIX_MAX;
			2: p = pixel_t'($urandom_range(0, 15));
			default: p = pixel_t'($urandom);
		endcase
		return p;
	endfunction

	// register writes only once the pipeline has drained
	task automatic write_op(input op_code_t op);
		start <= 1'b0;
		while (pending_pixels.size() != 0) @(negedge clk);
		op_select_we <= 1'b1;
		op_select_wdata <= op;
		@(negedge clk);
		op_select_we <= 1'b0;
		active_op = op;
	endtask

	task automatic send_pixels(input pixel_t s, input pixel_t d, input int gap,
			input logic known, input pixel_t pix);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		src_pixel <= s;
		dst_pixel <= d;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_pixels.push_back(known ? pix : new_dst_pixel(active_op, s, d));
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** pixel_binary_op_unit: FAILED **");
			$finish;
		end
		if (arst_n && result_valid) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0d",
					$time, result_pixel);
				mismatches++;
			end else if (result_pixel !== pending_pixels[0]) begin
				$display("%0t: result_pixel mismatch, expected %0d, actual %0d",
					$time, pending_pixels[0], result_pixel);
				mismatches++;
				void'(pending_pixels.pop_front());
			end else begin
				void'(pending_pixels.pop_front());
			end
		end
	end

	initial begin
		int sent;
		int phase_len;
		int gap_max;
		directed_rows = '{
			// op after reset is copy, so the first rows need no write
			'{pbou_pkg::OP_COPY,   8'd0,   8'd255, 1'b1, 8'd0},
			'{pbou_pkg::OP_COPY,   8'd255, 8'd0,   1'b1, 8'd255},
			'{pbou_pkg::OP_ZCOPY,  8'd0,   8'd170, 1'b1, 8'd170},
			'{pbou_pkg::OP_ZCOPY,  8'd85,  8'd170, 1'b1, 8'd85},
			'{pbou_pkg::OP_ADD,    8'd255, 8'd1,   1'b1, 8'd0},
			'{pbou_pkg::OP_ADD,    8'd255, 8'd255, 1'b1, 8'd254},
			'{pbou_pkg::OP_AVG,    8'd255, 8'd255, 1'b1, 8'd255},
			'{pbou_pkg::OP_AVG,    8'd1,   8'd0,   1'b0, 8'd0},
			'{pbou_pkg::OP_ABSDIF, 8'd0,   8'd255, 1'b1, 8'd255},
			'{pbou_pkg::OP_ABSDIF, 8'd200, 8'd3,   1'b0, 8'd0},
			'{pbou_pkg::OP_SUB,    8'd1,   8'd0,   1'b1, 8'd255},
			'{pbou_pkg::OP_MUL,    8'd255, 8'd255, 1'b1, 8'd255},
			'{pbou_pkg::OP_MUL,    8'd15,  8'd17,  1'b0, 8'd0},
			'{pbou_pkg::OP_DIV,    8'd0,   8'd200, 1'b1, 8'd0},
			'{pbou_pkg::OP_DIV,    8'd1,   8'd255, 1'b1, 8'd255},
			'{pbou_pkg::OP_DIV,    8'd2,   8'd3,   1'b0, 8'd0},
			'{pbou_pkg::OP_DIV,    8'd255, 8'd0,   1'b1, 8'd0},
			'{pbou_pkg::OP_AND,    8'd170, 8'd85,  1'b1, 8'd0},
			'{pbou_pkg::OP_OR,     8'd170, 8'd85,  1'b1, 8'd255},
			'{pbou_pkg::OP_XOR,    8'd255, 8'd15,  1'b0, 8'd0},
			'{pbou_pkg::OP_MIN,    8'd0,   8'd255, 1'b1, 8'd0},
			'{pbou_pkg::OP_MAX,    8'd0,   8'd255, 1'b1, 8'd255},
			'{OP_RSVD_LO,          8'd5,   8'd77,  1'b1, 8'd77},
			'{OP_RSVD_MID,         8'd9,   8'd200, 1'b0, 8'd0},
			'{OP_RSVD_HI,          8'd255, 8'd0,   1'b1, 8'd0}
		};

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].op != active_op)
				write_op(directed_rows[i].op);
			send_pixels(directed_rows[i].src, directed_rows[i].dst, $urandom_range(0, 11),
				directed_rows[i].known, directed_rows[i].pix);
		end

		// random phases, one operation each, some with no gaps between transactions
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			write_op(op_code_t'($urandom_range(0, 15)));
			phase_len = $urandom_range(15, 60);
			if (phase_len > RANDOM_ITEMS - sent)
				phase_len = RANDOM_ITEMS - sent;
			gap_max = ($urandom_range(0, 2) == 0) ? 0 : 11;
			repeat (phase_len) begin
				send_pixels(rand_pixel(), rand_pixel(), $urandom_range(0, gap_max), 1'b0, '0);
				sent++;
			end
		end

		start <= 1'b0;
		while (pending_pixels.size() != 0) @(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
		if (mismatches == 0)
			$display("** pixel_binary_op_unit: PASSED **");
		else
			$display("** pixel_binary_op_unit: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/pbou_pkg.sv
rtl/pbou_op_mux.sv
rtl/pbou_div_cell.sv
rtl/pixel_binary_op_unit.sv
tb/pixel_binary_op_unit_tb.sv
